// File: src/brd_pkg.sv
// Package for the bounded ring deque: sizes, operation codes, payload types and index helpers.
`timescale 1ns / 1ps

package brd_pkg;

  // Built ring depth.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Capacity register.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int unsigned CAPX_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_NOP        = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     empty_flag;
    logic                     full_flag;
  } rsp_t;

  // Status of an item between the accept cycle and the result register.
  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
  } stat_t;

  // Move one slot toward the rear, wrapping after the last slot in use.
  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [IDX_W-1:0] last);
    logic [IDX_W-1:0] res;
    if (idx >= last) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Move one slot toward the front, wrapping from slot zero to the last slot in use.
  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] last);
    logic [IDX_W-1:0] res;
    if (idx == '0) begin
      res = last;
    end else begin
      res = idx - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

// File: src/brd_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module brd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Reads return the contents before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: src/bounded_ring_deque.sv
// Top level of the bounded ring deque: pointer logic, slot RAM and result register.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    in_data_i   (brd_pkg::req_t)
//   out       output     out_valid_o / out_stall_i  out_data_o  (brd_pkg::rsp_t)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i  (capacity)
//
// One item is accepted per cycle while in_stall_o is low; its status is registered in
// the p1 stage at the transfer, and its result then moves into the output register.
// The pointer update and the slot write happen in the accept cycle; the two-port slot
// RAM reads the new front and rear slots into its output registers in that same edge.
// Reset clears the pointers and the occupancy and sets the capacity to 16; slots are
// left unwritten. A stalled output holds its result while one more item waits behind it.
`timescale 1ns / 1ps

module bounded_ring_deque (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  brd_pkg::req_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output brd_pkg::rsp_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brd_pkg::CAP_W-1:0]   cfg_data_i
);

  logic [brd_pkg::CAP_W-1:0]  capacity_q;
  logic [brd_pkg::IDX_W-1:0]  head_q, head_d;
  logic [brd_pkg::IDX_W-1:0]  tail_q, tail_d;
  logic [brd_pkg::CNT_W-1:0]  occ_q, occ_d;

  logic [brd_pkg::CAPX_W-1:0] cap_x;
  logic [brd_pkg::CNT_W-1:0]  cap_eff;
  logic [brd_pkg::IDX_W-1:0]  cap_last;

  logic                       in_fire;
  logic                       p1_adv;
  logic                       was_full;
  logic                       was_empty;
  brd_pkg::stat_t             stat_d;
  brd_pkg::stat_t             p1_q;
  logic                       p1_valid_q;

  logic                       we;
  logic [brd_pkg::IDX_W-1:0]  waddr;
  logic [brd_pkg::WORD_W-1:0] wdata_q;
  logic                       fwd_a_q, fwd_b_q;
  logic [brd_pkg::WORD_W-1:0] rdata_a, rdata_b;

  brd_pkg::rsp_t              res;
  brd_pkg::rsp_t              out_q;
  logic                       out_valid_q;

  // Effective capacity: zero acts as one, anything above the built depth as the depth.
  always_comb begin
    cap_x = brd_pkg::CAPX_W'(capacity_q);
    if (cap_x == '0) begin
      cap_eff = brd_pkg::CNT_W'(1);
    end else if (cap_x > brd_pkg::CAPX_W'(brd_pkg::DEPTH)) begin
      cap_eff = brd_pkg::CNT_W'(brd_pkg::DEPTH);
    end else begin
      cap_eff = cap_x[brd_pkg::CNT_W-1:0];
    end
    cap_last = brd_pkg::IDX_W'(cap_eff - brd_pkg::CNT_W'(1));
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= brd_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  assign p1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = p1_valid_q && !p1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign was_full  = occ_q >= cap_eff;
  assign was_empty = occ_q == '0;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    we        = 1'b0;
    waddr     = head_q;
    stat_d.ok = 1'b1;
    if (in_fire) begin
      unique case (in_data_i.op)
        brd_pkg::OP_PUSH_FRONT, brd_pkg::OP_PUSH_REAR: begin
          if (was_full) begin
            stat_d.ok = 1'b0;
          end else begin
            we    = 1'b1;
            occ_d = occ_q + brd_pkg::CNT_W'(1);
            if (was_empty) begin
              tail_d = head_q;
              waddr  = head_q;
            end else if (in_data_i.op == brd_pkg::OP_PUSH_FRONT) begin
              head_d = brd_pkg::step_down(head_q, cap_last);
              waddr  = head_d;
            end else begin
              tail_d = brd_pkg::step_up(tail_q, cap_last);
              waddr  = tail_d;
            end
          end
        end
        brd_pkg::OP_POP_FRONT, brd_pkg::OP_POP_REAR: begin
          if (was_empty) begin
            stat_d.ok = 1'b0;
          end else begin
            occ_d = occ_q - brd_pkg::CNT_W'(1);
            if (occ_q == brd_pkg::CNT_W'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else if (in_data_i.op == brd_pkg::OP_POP_FRONT) begin
              head_d = brd_pkg::step_up(head_q, cap_last);
            end else begin
              tail_d = brd_pkg::step_down(tail_q, cap_last);
            end
          end
        end
        default: begin
          // No change, including the unused codes.
        end
      endcase
    end
    stat_d.empty = occ_d == '0;
    stat_d.full  = occ_d >= cap_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // The RAM reads the slots under the next pointers. When the write hits one of
  // them, the word comes from the forwarding register instead.
  brd_ram #(
    .WIDTH (brd_pkg::WORD_W),
    .DEPTH (brd_pkg::DEPTH)
  ) u_slots (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (in_data_i.data_value),
    .raddr_a_i (head_d),
    .raddr_b_i (tail_d),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i) begin
    wdata_q <= in_data_i.data_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= we && (waddr == head_d);
      fwd_b_q <= we && (waddr == tail_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (in_fire) begin
      p1_valid_q <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_q <= stat_d;
    end
  end

  always_comb begin
    res.ok         = p1_q.ok;
    res.empty_flag = p1_q.empty;
    res.full_flag  = p1_q.full;
    if (p1_q.empty) begin
      res.front_word = '1;
      res.rear_word  = '1;
    end else begin
      res.front_word = fwd_a_q ? wdata_q : rdata_a;
      res.rear_word  = fwd_b_q ? wdata_q : rdata_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_adv) begin
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv && p1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= brd_pkg::CNT_W'(brd_pkg::DEPTH))
    else $error("occupancy exceeds the built depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("pointers not parked while the deque is empty");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && occ_q == '0 && (in_data_i.op == brd_pkg::OP_POP_FRONT ||
     in_data_i.op == brd_pkg::OP_POP_REAR)) |=> (p1_valid_q && !p1_q.ok))
    else $error("pop from an empty deque not refused");

  a_stat_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> (p1_q.empty == (occ_q == '0)))
    else $error("pending empty flag disagrees with the occupancy");

  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> p1_valid_q)
    else $error("accepted transfer lost before the result register");

endmodule

// File: test/tb.sv
// Testbench for the bounded ring deque: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIMIT = 500000;
  localparam int unsigned TOTAL_ITEMS = 625;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  // Tracks the deque contents and queues the result expected for every accepted request.
  class deque_scoreboard;
    logic signed [brd_pkg::WORD_W-1:0] words[brd_pkg::DEPTH];
    logic [brd_pkg::DEPTH-1:0] ever_written;
    int unsigned head_slot, tail_slot, held, cap_setting;
    brd_pkg::rsp_t snapshot_q[$];
    int unsigned errors;

    function new();
      ever_written = '0;
      head_slot = 0;
      tail_slot = 0;
      held = 0;
      cap_setting = 32'(brd_pkg::CAP_RESET);
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned usable_slots();
      if (cap_setting == 0) return 1;
      if (cap_setting > brd_pkg::DEPTH) return brd_pkg::DEPTH;
      return cap_setting;
    endfunction

    function int unsigned next_slot(int unsigned idx, int unsigned lim);
      return (idx >= lim - 1) ? 0 : idx + 1;
    endfunction

    function int unsigned prev_slot(int unsigned idx, int unsigned lim);
      return (idx == 0) ? lim - 1 : idx - 1;
    endfunction

    function int unsigned pending();
      return snapshot_q.size();
    endfunction

    function bit every_slot_written();
      return &ever_written;
    endfunction

    function void note_capacity(logic [brd_pkg::CAP_W-1:0] value);
      cap_setting = 32'(value);
    endfunction

    function void note_request(brd_pkg::req_t req);
      int unsigned lim;
      int unsigned slot;
      bit was_full;
      bit was_empty;
      brd_pkg::rsp_t snap;
      lim = usable_slots();
      was_full = held >= lim;
      was_empty = held == 0;
      snap.ok = 1'b1;
      case (req.op)
        brd_pkg::OP_PUSH_FRONT, brd_pkg::OP_PUSH_REAR: begin
          if (was_full) begin
            snap.ok = 1'b0;
          end else begin
            // A push into an empty deque lands on the head slot from either end.
            if (was_empty) begin
              tail_slot = head_slot;
            end else if (req.op == brd_pkg::OP_PUSH_FRONT) begin
              head_slot = prev_slot(head_slot, lim);
            end else begin
              tail_slot = next_slot(tail_slot, lim);
            end
            slot = (req.op == brd_pkg::OP_PUSH_FRONT) ? head_slot : tail_slot;
            words[slot] = req.data_value;
            ever_written[slot] = 1'b1;
            held++;
          end
        end
        brd_pkg::OP_POP_FRONT, brd_pkg::OP_POP_REAR: begin
          if (was_empty) begin
            snap.ok = 1'b0;
          end else begin
            held--;
            if (held == 0) begin
              head_slot = 0;
              tail_slot = 0;
            end else if (req.op == brd_pkg::OP_POP_FRONT) begin
              head_slot = next_slot(head_slot, lim);
            end else begin
              tail_slot = prev_slot(tail_slot, lim);
            end
          end
        end
        default: begin
        end
      endcase
      snap.empty_flag = held == 0;
      snap.full_flag = held >= lim;
      snap.front_word = (held == 0) ? '1 : words[head_slot];
      snap.rear_word = (held == 0) ? '1 : words[tail_slot];
      snapshot_q.push_back(snap);
    endfunction

    function void check_snapshot(brd_pkg::rsp_t got);
      brd_pkg::rsp_t want;
      if (snapshot_q.size() == 0) begin
        $error("result %h arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = snapshot_q.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.front_word !== want.front_word) begin
        $error("front_word: expected %0d, got %0d", want.front_word, got.front_word);
        errors++;
      end
      if (got.rear_word !== want.rear_word) begin
        $error("rear_word: expected %0d, got %0d", want.rear_word, got.rear_word);
        errors++;
      end
      if (got.empty_flag !== want.empty_flag) begin
        $error("empty_flag: expected %0d, got %0d", want.empty_flag, got.empty_flag);
        errors++;
      end
      if (got.full_flag !== want.full_flag) begin
        $error("full_flag: expected %0d, got %0d", want.full_flag, got.full_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  brd_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  brd_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brd_pkg::CAP_W-1:0] cfg_data = '0;

  deque_scoreboard sb;
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned in_xfers = 0;
  int unsigned cfg_xfers = 0;
  int unsigned items_sent = 0;
  int stall_left = 0;

  bounded_ring_deque dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_snapshot(out_data);
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        in_xfers++;
      end
      if (cfg_valid && cfg_ready) begin
        sb.note_capacity(cfg_data);
        cfg_xfers++;
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [brd_pkg::OP_W-1:0] op,
                         input logic signed [brd_pkg::WORD_W-1:0] word);
    int gap;
    int unsigned seen;
    brd_pkg::req_t req;
    gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.op = op;
    req.data_value = word;
    in_valid <= 1'b1;
    in_data <= req;
    seen = in_xfers;
    do @(negedge clk_i); while (in_xfers == seen);
    items_sent++;
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [brd_pkg::CAP_W-1:0] value);
    int unsigned seen;
    cfg_valid <= 1'b1;
    cfg_data <= value;
    seen = cfg_xfers;
    do @(negedge clk_i); while (cfg_xfers == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_deque();
    while (sb.held != 0) begin
      send_op($urandom_range(0, 1) ? brd_pkg::OP_POP_FRONT : brd_pkg::OP_POP_REAR, $urandom);
    end
  endtask

  function automatic logic [brd_pkg::CAP_W-1:0] pick_capacity();
    logic [brd_pkg::CAP_W-1:0] picks[8];
    picks = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd15, 5'd16, 5'd17, 5'd31};
    if ($urandom_range(0, 9) < 3) begin
      return brd_pkg::CAP_W'($urandom_range(1, brd_pkg::DEPTH));
    end
    return picks[$urandom_range(0, 7)];
  endfunction

  function automatic logic signed [brd_pkg::WORD_W-1:0] pick_word();
    logic signed [brd_pkg::WORD_W-1:0] corners[4];
    corners = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0};
    if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [brd_pkg::OP_W-1:0] pick_op(input mix_e mix);
    int push_pct;
    int roll;
    push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 30 : 50;
    roll = $urandom_range(0, 99);
    if (roll < 3) return brd_pkg::OP_NOP;
    if (roll < 6) begin
      return brd_pkg::OP_W'($urandom_range(brd_pkg::OP_NOP + 1, (1 << brd_pkg::OP_W) - 1));
    end
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? brd_pkg::OP_PUSH_REAR : brd_pkg::OP_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? brd_pkg::OP_POP_REAR : brd_pkg::OP_POP_FRONT;
  endfunction

  initial begin
    wait (cycle_count >= LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int phase;
    mix_e mix;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Refused pops on the empty deque, then the no-change and spare codes.
    send_op(brd_pkg::OP_POP_FRONT, 32'sd7);
    send_op(brd_pkg::OP_POP_REAR, -32'sd7);
    send_op(brd_pkg::OP_NOP, -32'sd1);
    send_op(brd_pkg::OP_NOP + 3'd1, 32'sd1);
    send_op(brd_pkg::OP_NOP + 3'd2, 32'sd2);
    send_op(brd_pkg::OP_NOP + 3'd3, 32'sd3);
    // Push into the empty deque, grow at both ends, shrink back to empty.
    send_op(brd_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
    send_op(brd_pkg::OP_PUSH_REAR, 32'sh80000000);
    send_op(brd_pkg::OP_PUSH_FRONT, -32'sd1);
    send_op(brd_pkg::OP_PUSH_REAR, 32'sd0);
    send_op(brd_pkg::OP_POP_FRONT, 32'sd0);
    send_op(brd_pkg::OP_POP_REAR, 32'sd0);
    send_op(brd_pkg::OP_POP_REAR, 32'sd0);
    send_op(brd_pkg::OP_POP_FRONT, 32'sd0);
    send_op(brd_pkg::OP_POP_FRONT, 32'sd0);
    // A single slot: full after one push.
    wait_idle(4);
    write_capacity(5'd1);
    send_op(brd_pkg::OP_PUSH_REAR, 32'sh5a5a5a5a);
    send_op(brd_pkg::OP_PUSH_FRONT, 32'sh12345678);
    send_op(brd_pkg::OP_NOP, 32'sd0);
    send_op(brd_pkg::OP_POP_FRONT, 32'sd0);
    send_op(brd_pkg::OP_PUSH_FRONT, 32'sha5a5a5a5);
    send_op(brd_pkg::OP_POP_REAR, 32'sd0);
    // Zero capacity behaves as one slot.
    wait_idle(4);
    write_capacity(5'd0);
    send_op(brd_pkg::OP_PUSH_REAR, 32'sd1);
    send_op(brd_pkg::OP_PUSH_REAR, 32'sd2);
    send_op(brd_pkg::OP_POP_REAR, 32'sd0);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      wait_idle(4);
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // Full capacity and a push-heavy mix first, to fill slots with written data.
        write_capacity(5'd16);
        mix = MIX_FILL;
      end else begin
        // Contents survive a capacity change only once no slot is left unwritten.
        if (sb.held != 0 && (!sb.every_slot_written() || $urandom_range(0, 1) == 0)) begin
          drain_deque();
          wait_idle(4);
        end
        write_capacity(pick_capacity());
        mix = mix_e'($urandom_range(0, 2));
      end
      repeat ($urandom_range(25, 60)) send_op(pick_op(mix), pick_word());
      phase++;
    end

    wait_idle(10);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/brd_pkg.sv
src/brd_ram.sv
src/bounded_ring_deque.sv
test/tb.sv
